[hw/rtl/qfa_pkg.sv]
// Shared types, constants and step functions of the Q16.16 arithmetic unit.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package qfa_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIV_SHIFT   = 8;
    localparam int ROOT_STEPS  = 16;
    localparam int DIV_STEPS   = 32;
    localparam int STAGES      = 2 * DIV_STEPS + 1;
    localparam int DMAG_W      = WORD_W - DIV_SHIFT;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_SQRT = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     error;
    } t_out_item;

    // classified command; rem/quo/dvs double as the root working set for sqrt
    typedef struct packed {
        t_op               op;
        logic              err;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
        logic [DMAG_W-1:0] dmag;
        logic              neg_n;
        logic              neg_d;
    } t_cmd;

    // one restoring division step: shift dividend bit into remainder
    function automatic t_cmd div_step(t_cmd c);
        logic [WORD_W:0] t;
        logic            qbit;
        t_cmd            o;
        o    = c;
        t    = {c.rem, c.quo[WORD_W-1]};
        qbit = (t >= {1'b0, c.dvs});
        if (qbit) begin
            o.rem = WORD_W'(t - {1'b0, c.dvs});
        end else begin
            o.rem = t[WORD_W-1:0];
        end
        o.quo = {c.quo[WORD_W-2:0], qbit};
        return o;
    endfunction

    // one restoring root step; dvs holds the running root
    function automatic t_cmd sqrt_step(t_cmd c);
        logic [WORD_W-1:0] root;
        logic [WORD_W-1:0] rm;
        t_cmd              o;
        o    = c;
        root = {c.dvs[WORD_W-2:0], 1'b0};
        rm   = {c.rem[WORD_W-3:0], c.quo[WORD_W-1:WORD_W-2]};
        if (root < rm) begin
            root = root + 1'b1;
            rm   = rm - root;
            root = root + 1'b1;
        end
        o.dvs = root;
        o.rem = rm;
        o.quo = {c.quo[WORD_W-3:0], 2'b00};
        return o;
    endfunction

    // signed integer quotient into res, scaled remainder set up as next dividend
    function automatic t_cmd div_turn(t_cmd c);
        logic [WORD_W-1:0] rs;
        logic [WORD_W-1:0] r8;
        t_cmd              o;
        o     = c;
        o.res = (c.neg_n ^ c.neg_d) ? -c.quo : c.quo;
        rs    = c.neg_n ? -c.rem : c.rem;
        r8    = rs << DIV_SHIFT;
        o.quo = r8[WORD_W-1] ? -r8 : r8;
        o.rem = '0;
        o.dvs = WORD_W'(c.dmag);
        o.neg_n = r8[WORD_W-1];
        return o;
    endfunction

    function automatic t_out_item finish(t_cmd c);
        logic [WORD_W-1:0] q2;
        t_out_item         o;
        q2 = (c.neg_n ^ c.neg_d) ? -c.quo : c.quo;
        case (c.op)
            OP_DIV:  o.result = {c.res[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} + q2;
            OP_SQRT: o.result = {c.dvs[WORD_W-DIV_SHIFT:1], {DIV_SHIFT{1'b0}}};
            default: o.result = c.res;
        endcase
        if (c.err) begin
            o.result = '0;
        end
        o.error = c.err;
        return o;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qfa_front.sv]
// Front end: decodes an input word, does add/sub/mul outright and prepares
// division and root operands. Depends on qfa_pkg.
`default_nettype none

module qfa_front (
    input  qfa_pkg::t_in_item i_item,
    output qfa_pkg::t_cmd     o_cmd
);

    logic signed [2*qfa_pkg::WORD_W-1:0] w_prod;
    logic [qfa_pkg::WORD_W-1:0]          w_amag;
    logic [qfa_pkg::WORD_W-1:0]          w_bmag;
    logic signed [qfa_pkg::DMAG_W-1:0]   w_d;

    assign w_prod = i_item.operand_a * i_item.operand_b;
    assign w_amag = i_item.operand_a[qfa_pkg::WORD_W-1] ? -i_item.operand_a : i_item.operand_a;
    assign w_bmag = i_item.operand_b[qfa_pkg::WORD_W-1] ? -i_item.operand_b : i_item.operand_b;
    assign w_d    = i_item.operand_b[qfa_pkg::WORD_W-1:qfa_pkg::DIV_SHIFT];

    always_comb begin
        o_cmd = '{op: qfa_pkg::OP_ADD, default: '0};
        case (i_item.func)
            qfa_pkg::OP_ADD: begin
                o_cmd.res = i_item.operand_a + i_item.operand_b;
            end
            qfa_pkg::OP_SUB: begin
                o_cmd.op  = qfa_pkg::OP_SUB;
                o_cmd.res = i_item.operand_a - i_item.operand_b;
            end
            qfa_pkg::OP_MUL: begin
                o_cmd.op  = qfa_pkg::OP_MUL;
                o_cmd.res = w_prod[qfa_pkg::FRAC_BITS +: qfa_pkg::WORD_W];
            end
            qfa_pkg::OP_DIV: begin
                o_cmd.op = qfa_pkg::OP_DIV;
                if (w_d == '0) begin
                    o_cmd.err = 1'b1;
                end else begin
                    o_cmd.quo   = w_amag;
                    o_cmd.dvs   = w_bmag;
                    o_cmd.dmag  = w_d[qfa_pkg::DMAG_W-1] ? -w_d : w_d;
                    o_cmd.neg_n = i_item.operand_a[qfa_pkg::WORD_W-1];
                    o_cmd.neg_d = i_item.operand_b[qfa_pkg::WORD_W-1];
                end
            end
            qfa_pkg::OP_SQRT: begin
                o_cmd.op  = qfa_pkg::OP_SQRT;
                o_cmd.err = i_item.operand_a[qfa_pkg::WORD_W-1];
                o_cmd.quo = i_item.operand_a;
            end
            default: begin
                // unused codes give zero without error
                o_cmd.res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/qfa_queue.sv]
// Short command queue between front and back end, flip-flop storage.
// Depends on qfa_pkg.
`default_nettype none

module qfa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qfa_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output qfa_pkg::t_cmd o_head,
    output logic          o_head_valid
);

    qfa_pkg::t_cmd                r_mem [qfa_pkg::QUEUE_DEPTH];
    logic [qfa_pkg::QPTR_W-1:0]   r_wp;
    logic [qfa_pkg::QPTR_W-1:0]   r_rp;
    logic [qfa_pkg::QCNT_W-1:0]   r_cnt;
    logic [qfa_pkg::QCNT_W-1:0]   n_cnt;

    assign o_full       = (r_cnt == qfa_pkg::QCNT_W'(qfa_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/qfa_back.sv]
// Back end: fixed-length execution pipeline (two 32-step restoring divisions,
// 16-step root) and output register. Depends on qfa_pkg.
`default_nettype none

module qfa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qfa_pkg::t_cmd      i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qfa_pkg::t_out_item o_out_item
);

    localparam int LAST = qfa_pkg::STAGES - 1;

    qfa_pkg::t_cmd      r_stg [qfa_pkg::STAGES];
    logic               r_vld [qfa_pkg::STAGES];
    logic               r_out_valid;
    qfa_pkg::t_out_item r_out;
    logic               w_adv;

    // whole pipe holds while a finished word waits on the output
    assign w_adv       = !(r_out_valid && i_out_stall);
    assign o_pop       = w_adv && i_head_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    for (genvar k = 0; k < qfa_pkg::STAGES; k++) begin : g_stg
        qfa_pkg::t_cmd w_in;
        qfa_pkg::t_cmd n_c;
        logic          w_v;

        if (k == 0) begin : g_first
            assign w_in = i_head;
            assign w_v  = o_pop;
        end else begin : g_next
            assign w_in = r_stg[k-1];
            assign w_v  = r_vld[k-1];
        end

        always_comb begin
            n_c = w_in;
            if (w_in.op == qfa_pkg::OP_DIV && !w_in.err) begin
                if (k == qfa_pkg::DIV_STEPS) begin
                    n_c = qfa_pkg::div_turn(w_in);
                end else begin
                    n_c = qfa_pkg::div_step(w_in);
                end
            end else if (w_in.op == qfa_pkg::OP_SQRT && !w_in.err
                         && k < qfa_pkg::ROOT_STEPS) begin
                n_c = qfa_pkg::sqrt_step(w_in);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_stg[k] <= n_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= qfa_pkg::finish(r_stg[LAST]);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/q16_fixed_point_alu.sv]
// Top level of the Q16.16 arithmetic unit: front end, command queue, back end.
// Depends on qfa_pkg, qfa_front, qfa_queue and qfa_back.
//
// Signed Q16.16 add, sub, mul, div and sqrt; one word in and one word out per
// cycle unless o_in_stall or i_out_stall holds the flow. Every operation takes
// the same path, so results leave in order; that path is the queue, the
// 65-stage back-end pipeline (two chained 32-step restoring divisions with a
// turn stage between them) and the output register. A four-word queue
// decouples input from output: o_in_stall rises only when it is full. A
// divisor from 0 to 255 or a negative root operand gives result 0 with error
// set; unused codes give 0 without error.
`default_nettype none

module q16_fixed_point_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  qfa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qfa_pkg::t_out_item o_out_item
);

    qfa_pkg::t_cmd w_cmd;
    qfa_pkg::t_cmd w_head;
    logic          w_full;
    logic          w_push;
    logic          w_pop;
    logic          w_head_valid;

    assign w_push     = i_in_valid && !w_full;
    assign o_in_stall = w_full;

    qfa_front u_front (
        .i_item (i_in_item),
        .o_cmd  (w_cmd)
    );

    qfa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid)
    );

    qfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

[hw/rtl/qfa_checker.sv]
// Port-level checks for q16_fixed_point_alu, bound to the top level.
// Depends on qfa_pkg.
`default_nettype none

module qfa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input qfa_pkg::t_out_item o_out_item
);

    // pipe and queue come up empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("output or stall set straight after reset");

    // an error word always carries zero
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.error) |-> (o_out_item.result == '0))
        else $error("error word with non-zero result");

    // queue only fills on a pushed word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall rose without an offered word");

    // held result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output word changed");

endmodule

bind q16_fixed_point_alu qfa_checker u_chk (.*);

`default_nettype wire
